// ===== rtl/core/life_cell_automaton_step_macros.svh =====
// Assertion macros used by the checker of the life cell automaton step block.
`ifndef LIFE_CELL_AUTOMATON_STEP_MACROS_SVH
`define LIFE_CELL_AUTOMATON_STEP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCAS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCAS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lcas_pkg.sv =====
// Package with sizes, codes, types and helpers of the life cell automaton step block.
package lcas_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  localparam int CFG_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(1);

  localparam int MIN_DIM = 2;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam int WIN_W = 9;
  localparam int CENTRE_BIT = 4;
  localparam int NBR_CNT_W = 4;
  localparam logic [NBR_CNT_W-1:0] NBR_BIRTH = NBR_CNT_W'(3);
  localparam logic [NBR_CNT_W-1:0] NBR_SURVIVE = NBR_CNT_W'(2);

  localparam logic [WIN_W-1:0] MASK_TOP = 9'h049;
  localparam logic [WIN_W-1:0] MASK_BOTTOM = 9'h124;
  localparam logic [WIN_W-1:0] MASK_LEFT = 9'h007;
  localparam logic [WIN_W-1:0] MASK_RIGHT = 9'h1C0;

  typedef struct packed {
    logic             alive;
    logic [COL_W-1:0] line_addr;
    logic             emit;
    logic             border_top;
    logic             border_bottom;
    logic             border_left;
    logic             border_right;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic             next_alive;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_end;
  } result_t;

  function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int maxv);
    int x;
    x = int'(v);
    if (x < MIN_DIM) begin
      x = MIN_DIM;
    end else if (x > maxv) begin
      x = maxv;
    end
    return x;
  endfunction

endpackage

// ===== rtl/core/lcas_cmd_queue.sv =====
// Short command queue that decouples the front stage from the back stage.
module lcas_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  lcas_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output lcas_pkg::cmd_t rd_data,
  output logic          empty
);

  lcas_pkg::cmd_t                   mem [lcas_pkg::CMD_DEPTH];
  logic [lcas_pkg::CMD_PTR_W-1:0] wptr;
  logic [lcas_pkg::CMD_PTR_W-1:0] rptr;
  logic [lcas_pkg::CMD_CNT_W-1:0] count;

  assign full = (count == lcas_pkg::CMD_CNT_W'(lcas_pkg::CMD_DEPTH));
  assign empty = (count == '0);
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + lcas_pkg::CMD_PTR_W'(1);
      end
      if (rd_en) begin
        rptr <= rptr + lcas_pkg::CMD_PTR_W'(1);
      end
      case ({wr_en, rd_en})
        2'b10: count <= count + lcas_pkg::CMD_CNT_W'(1);
        2'b01: count <= count - lcas_pkg::CMD_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/lcas_front.sv =====
// Front stage: accepts cells, tracks raster positions and builds commands.
module lcas_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          cell_alive,
  input  logic                          drain,
  output logic                          full,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lcas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcas_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          cmd_full,
  output logic                          cmd_push,
  output lcas_pkg::cmd_t                cmd
);

  logic [lcas_pkg::COL_W-1:0] cols_last;
  logic [lcas_pkg::ROW_W-1:0] rows_last;
  logic [lcas_pkg::ROW_W-1:0] in_row;
  logic [lcas_pkg::COL_W-1:0] in_col;
  logic [lcas_pkg::ROW_W-1:0] out_row;
  logic [lcas_pkg::COL_W-1:0] out_col;
  logic                       pending;

  logic accept;
  logic in_tail;
  logic skip;
  logic emit;
  logic at_bottom;
  logic at_right;
  logic last;
  logic cfg_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign full = cmd_full;
  assign accept = push && !cmd_full;

  always_comb begin
    in_tail = pending &&
      ((in_row == '0) || ((in_row == lcas_pkg::ROW_W'(1)) && (in_col == '0)));
    skip = drain && !in_tail;
    emit = pending || ((in_row != '0) && (in_col != '0));
    at_bottom = (out_row == rows_last);
    at_right = (out_col == cols_last);
    last = at_bottom && at_right;
    cmd_push = accept && !skip;

    cmd.alive = cell_alive && !drain;
    cmd.line_addr = in_col;
    cmd.emit = emit;
    cmd.border_top = (out_row == '0);
    cmd.border_bottom = at_bottom;
    cmd.border_left = (out_col == '0);
    cmd.border_right = at_right;
    cmd.row = lcas_pkg::POS_W'(out_row);
    cmd.col = lcas_pkg::POS_W'(out_col);
    cmd.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_last <= lcas_pkg::COL_W'(lcas_pkg::MAX_COLS - 1);
      rows_last <= lcas_pkg::ROW_W'(lcas_pkg::MAX_ROWS - 1);
      in_row <= '0;
      in_col <= '0;
      out_row <= '0;
      out_col <= '0;
      pending <= 1'b0;
    end else if (cfg_write) begin
      if (cfg_index == lcas_pkg::REG_GRID_COLS || cfg_index == lcas_pkg::REG_GRID_ROWS) begin
        in_row <= '0;
        in_col <= '0;
        out_row <= '0;
        out_col <= '0;
        pending <= 1'b0;
      end
      if (cfg_index == lcas_pkg::REG_GRID_COLS) begin
        cols_last <= lcas_pkg::COL_W'(lcas_pkg::clamp_dim(cfg_data, lcas_pkg::MAX_COLS) - 1);
      end
      if (cfg_index == lcas_pkg::REG_GRID_ROWS) begin
        rows_last <= lcas_pkg::ROW_W'(lcas_pkg::clamp_dim(cfg_data, lcas_pkg::MAX_ROWS) - 1);
      end
    end else if (cmd_push) begin
      if (in_col == cols_last) begin
        in_col <= '0;
        in_row <= (in_row == rows_last) ? '0 : in_row + lcas_pkg::ROW_W'(1);
      end else begin
        in_col <= in_col + lcas_pkg::COL_W'(1);
      end
      if (emit) begin
        pending <= 1'b1;
        if (at_right) begin
          out_col <= '0;
          out_row <= at_bottom ? '0 : out_row + lcas_pkg::ROW_W'(1);
        end else begin
          out_col <= out_col + lcas_pkg::COL_W'(1);
        end
        if (last && drain) begin
          in_row <= '0;
          in_col <= '0;
          out_row <= '0;
          out_col <= '0;
          pending <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/lcas_back.sv =====
// Back stage: line store, neighbour window, rule evaluation and result queue.
module lcas_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_empty,
  input  lcas_pkg::cmd_t             cmd_data,
  output logic                       cmd_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic                       next_alive,
  output logic [lcas_pkg::POS_W-1:0] cell_row,
  output logic [lcas_pkg::POS_W-1:0] cell_col,
  output logic                       frame_end
);

  // Each line store entry holds the cell two rows up and the cell one row up.
  logic [1:0]                      lines [lcas_pkg::MAX_COLS];
  logic [1:0]                      line_rd;
  logic                            a_valid;
  lcas_pkg::cmd_t                  a_cmd;
  logic [lcas_pkg::WIN_W-1:0]      win;
  logic [lcas_pkg::WIN_W-1:0]      win_next;
  logic [lcas_pkg::WIN_W-1:0]      win_masked;
  logic [lcas_pkg::NBR_CNT_W-1:0]  nbr_count;
  logic                            res_push;
  lcas_pkg::result_t               res;

  lcas_pkg::result_t               res_mem [lcas_pkg::OUT_DEPTH];
  logic [lcas_pkg::OUT_PTR_W-1:0]  o_wptr;
  logic [lcas_pkg::OUT_PTR_W-1:0]  o_rptr;
  logic [lcas_pkg::OUT_CNT_W-1:0]  o_count;
  logic                            res_pop;

  assign cmd_pop = !cmd_empty &&
    ((int'(o_count) + int'(a_valid)) < lcas_pkg::OUT_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      line_rd <= lines[cmd_data.line_addr];
      a_cmd <= cmd_data;
    end
    if (a_valid) begin
      lines[a_cmd.line_addr] <= {line_rd[0], a_cmd.alive};
    end
  end

  always_comb begin
    win_next = {a_cmd.alive, line_rd[0], line_rd[1], win[lcas_pkg::WIN_W-1:3]};
    win_masked = win_next;
    if (a_cmd.border_top) begin
      win_masked = win_masked & ~lcas_pkg::MASK_TOP;
    end
    if (a_cmd.border_bottom) begin
      win_masked = win_masked & ~lcas_pkg::MASK_BOTTOM;
    end
    if (a_cmd.border_left) begin
      win_masked = win_masked & ~lcas_pkg::MASK_LEFT;
    end
    if (a_cmd.border_right) begin
      win_masked = win_masked & ~lcas_pkg::MASK_RIGHT;
    end
    nbr_count = '0;
    for (int i = 0; i < lcas_pkg::WIN_W; i++) begin
      if (i != lcas_pkg::CENTRE_BIT) begin
        nbr_count = nbr_count + lcas_pkg::NBR_CNT_W'(win_masked[i]);
      end
    end
    res.next_alive = (nbr_count == lcas_pkg::NBR_BIRTH) ||
      (win_masked[lcas_pkg::CENTRE_BIT] && (nbr_count == lcas_pkg::NBR_SURVIVE));
    res.row = a_cmd.row;
    res.col = a_cmd.col;
    res.frame_end = a_cmd.last;
    res_push = a_valid && a_cmd.emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      win <= '0;
    end else begin
      a_valid <= cmd_pop;
      if (a_valid) begin
        win <= win_next;
      end
    end
  end

  assign empty = (o_count == '0);
  assign res_pop = pop && !empty;
  assign next_alive = res_mem[o_rptr].next_alive;
  assign cell_row = res_mem[o_rptr].row;
  assign cell_col = res_mem[o_rptr].col;
  assign frame_end = res_mem[o_rptr].frame_end;

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[o_wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wptr <= '0;
      o_rptr <= '0;
      o_count <= '0;
    end else begin
      if (res_push) begin
        o_wptr <= o_wptr + lcas_pkg::OUT_PTR_W'(1);
      end
      if (res_pop) begin
        o_rptr <= o_rptr + lcas_pkg::OUT_PTR_W'(1);
      end
      case ({res_push, res_pop})
        2'b10: o_count <= o_count + lcas_pkg::OUT_CNT_W'(1);
        2'b01: o_count <= o_count - lcas_pkg::OUT_CNT_W'(1);
        default: o_count <= o_count;
      endcase
    end
  end

endmodule

// ===== rtl/core/life_cell_automaton_step.sv =====
// Top level of the streaming B3/S23 life cell automaton step block.
// The block takes one cell per clock in raster order while full is low and returns one
// result per clock once the stream is flowing and pop is high. Each result belongs to the
// cell one row plus one cell behind the input and passes the command queue, the line read
// register and the result queue. The rate is set by the line store, a single memory that is
// read and written once per cell. Cells outside the grid count as dead. The tail of a frame
// is flushed by the next frame's cells or by drain requests. Write grid_cols and grid_rows
// only while the block is idle; a write restarts the raster position at row 0, column 0.
module life_cell_automaton_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           cell_alive,
  input  logic                           drain,
  output logic                           empty,
  input  logic                           pop,
  output logic                           next_alive,
  output logic [lcas_pkg::POS_W-1:0]     cell_row,
  output logic [lcas_pkg::POS_W-1:0]     cell_col,
  output logic                           frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lcas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lcas_pkg::CFG_W-1:0]     cfg_data
);

  logic           q_full;
  logic           q_push;
  lcas_pkg::cmd_t q_wr_data;
  logic           q_pop;
  lcas_pkg::cmd_t q_rd_data;
  logic           q_empty;

  lcas_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .cell_alive (cell_alive),
    .drain      (drain),
    .full       (full),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd_full   (q_full),
    .cmd_push   (q_push),
    .cmd        (q_wr_data)
  );

  lcas_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  lcas_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_empty  (q_empty),
    .cmd_data   (q_rd_data),
    .cmd_pop    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .next_alive (next_alive),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .frame_end  (frame_end)
  );

endmodule

// ===== rtl/core/lcas_checker.sv =====
// Port-level assertion checker for the life cell automaton step block, with its bind.
`include "life_cell_automaton_step_macros.svh"

module lcas_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       empty,
  input logic                       pop,
  input logic                       next_alive,
  input logic [lcas_pkg::POS_W-1:0] cell_row,
  input logic [lcas_pkg::POS_W-1:0] cell_col,
  input logic                       frame_end
);

  `LCAS_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(next_alive) && $stable(cell_row) && $stable(cell_col) && $stable(frame_end), "Waiting result changed before it was taken.")

  `LCAS_ASSERT_NOW(a_empty_after_reset, $fell(rst), empty, "Result present right after reset.")

  `LCAS_ASSERT_NOW(a_frame_end_corner, !empty && frame_end, (cell_row != '0) && (cell_col != '0), "Frame end flagged off the last cell.")

  `LCAS_ASSERT_NEXT(a_frame_restart, pop && !empty && frame_end, empty || ((cell_row == '0) && (cell_col == '0)), "Next frame does not start at the first cell.")

endmodule

bind life_cell_automaton_step lcas_checker u_checker (.*);

// ===== verif/tb_life_cell_automaton_step.sv =====
// Testbench for the life cell automaton step block, checked against a B3/S23 predictor.
`timescale 1ns / 100ps

class life_scoreboard;
  bit [lcas_pkg::CFG_W-1:0] cols_reg;
  bit [lcas_pkg::CFG_W-1:0] rows_reg;
  bit upper_store [lcas_pkg::MAX_COLS];
  bit middle_store [lcas_pkg::MAX_COLS];
  bit [lcas_pkg::WIN_W-1:0] window;
  int unsigned in_row;
  int unsigned in_col;
  int unsigned out_row;
  int unsigned out_col;
  bit flowing;
  lcas_pkg::result_t due_q[$];
  int unsigned errors;

  function new();
    cols_reg = lcas_pkg::CFG_W'(lcas_pkg::MAX_COLS);
    rows_reg = lcas_pkg::CFG_W'(lcas_pkg::MAX_ROWS);
    foreach (upper_store[i]) begin
      upper_store[i] = 1'b0;
      middle_store[i] = 1'b0;
    end
    window = '0;
    errors = 0;
    restart();
  endfunction

  function void restart();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
    flowing = 1'b0;
  endfunction

  function void write_reg(bit [lcas_pkg::CFG_IDX_W-1:0] idx, bit [lcas_pkg::CFG_W-1:0] val);
    if (idx == lcas_pkg::REG_GRID_COLS) begin
      cols_reg = val;
    end else if (idx == lcas_pkg::REG_GRID_ROWS) begin
      rows_reg = val;
    end else begin
      return;
    end
    restart();
  endfunction

  function int unsigned used_size(bit [lcas_pkg::CFG_W-1:0] v, int unsigned maxv);
    if (v < lcas_pkg::MIN_DIM) return lcas_pkg::MIN_DIM;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function int unsigned used_cols();
    return used_size(cols_reg, lcas_pkg::MAX_COLS);
  endfunction

  function int unsigned used_rows();
    return used_size(rows_reg, lcas_pkg::MAX_ROWS);
  endfunction

  // A drain only does work while the previous frame's tail is still owed.
  function bit tail_open();
    return flowing && (in_row == 0 || (in_row == 1 && in_col == 0));
  endfunction

  function void note_request(bit alive, bit drn);
    int unsigned cols;
    int unsigned rows;
    int unsigned c;
    int live;
    bit now_cell;
    bit up;
    bit mid;
    bit emit;
    bit last;
    bit [lcas_pkg::WIN_W-1:0] win;
    lcas_pkg::result_t r;
    cols = used_cols();
    rows = used_rows();
    if (drn && !tail_open()) return;
    now_cell = drn ? 1'b0 : alive;
    c = (in_col >= cols) ? 0 : in_col;
    up = upper_store[c];
    mid = middle_store[c];
    upper_store[c] = mid;
    middle_store[c] = now_cell;
    window = {now_cell, mid, up, window[8:3]};
    emit = flowing || (in_row >= 1 && in_col >= 1);
    in_col++;
    if (in_col >= cols) begin
      in_col = 0;
      in_row++;
      if (in_row >= rows) in_row = 0;
    end
    if (!emit) return;
    flowing = 1'b1;
    win = window;
    if (out_row == 0) win &= ~lcas_pkg::MASK_TOP;
    if (out_row + 1 >= rows) win &= ~lcas_pkg::MASK_BOTTOM;
    if (out_col == 0) win &= ~lcas_pkg::MASK_LEFT;
    if (out_col + 1 >= cols) win &= ~lcas_pkg::MASK_RIGHT;
    live = $countones(win) - int'(win[lcas_pkg::CENTRE_BIT]);
    last = (out_row + 1 >= rows) && (out_col + 1 >= cols);
    r.next_alive = (live == 3) || (win[lcas_pkg::CENTRE_BIT] && live == 2);
    r.row = lcas_pkg::POS_W'(out_row);
    r.col = lcas_pkg::POS_W'(out_col);
    r.frame_end = last;
    due_q.push_back(r);
    out_col++;
    if (out_col >= cols) begin
      out_col = 0;
      out_row++;
      if (out_row >= rows) out_row = 0;
    end
    if (last && drn) restart();
  endfunction

  function void report(string what, logic [lcas_pkg::POS_W-1:0] want,
                       logic [lcas_pkg::POS_W-1:0] got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
  endfunction

  function void check_result(lcas_pkg::result_t got);
    lcas_pkg::result_t want;
    if (due_q.size() == 0) begin
      report("unexpected result, row", '0, got.row);
      return;
    end
    want = due_q.pop_front();
    if (got.next_alive !== want.next_alive) report("next_alive", want.next_alive, got.next_alive);
    if (got.row !== want.row) report("cell_row", want.row, got.row);
    if (got.col !== want.col) report("cell_col", want.col, got.col);
    if (got.frame_end !== want.frame_end) report("frame_end", want.frame_end, got.frame_end);
  endfunction
endclass

module tb_life_cell_automaton_step;

  localparam logic [lcas_pkg::CFG_IDX_W-1:0] REG_SPARE = lcas_pkg::CFG_IDX_W'(3);
  localparam int RANDOM_ITEMS = 350;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic cell_alive = 1'b0;
  logic drain = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic next_alive;
  logic [lcas_pkg::POS_W-1:0] cell_row;
  logic [lcas_pkg::POS_W-1:0] cell_col;
  logic frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [lcas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lcas_pkg::CFG_W-1:0] cfg_data = '0;

  life_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned useful_sent = 0;
  int unsigned cycle_count = 0;

  life_cell_automaton_step i_dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic send(input bit alive, input bit drn);
    int unsigned gap;
    bit useful;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push <= 1'b1;
    cell_alive <= alive;
    drain <= drn;
    do @(posedge clk); while (full);
    burst_left--;
    useful = !drn || sb.tail_open();
    sb.note_request(alive, drn);
    if (useful) useful_sent++;
  endtask

  task automatic write_reg(input logic [lcas_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lcas_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic config_grid(input logic [lcas_pkg::CFG_W-1:0] c,
                             input logic [lcas_pkg::CFG_W-1:0] r, input bit rows_first);
    if (rows_first) begin
      write_reg(lcas_pkg::REG_GRID_ROWS, r);
      write_reg(lcas_pkg::REG_GRID_COLS, c);
    end else begin
      write_reg(lcas_pkg::REG_GRID_COLS, c);
      write_reg(lcas_pkg::REG_GRID_ROWS, r);
    end
    cfg_valid <= 1'b0;
  endtask

  // The block may still be working on a cell that gives no result, so wait a little longer.
  task automatic wait_drained();
    push <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic flush_tail();
    while (sb.tail_open()) send($urandom_range(0, 1), 1'b1);
  endtask

  task automatic stream_part(input int unsigned n_cells);
    int unsigned density;
    density = $urandom_range(0, 100);
    for (int unsigned k = 0; k < n_cells; k++) begin
      send($urandom_range(0, 99) < density, 1'b0);
    end
    wait_drained();
  endtask

  task automatic stream_frames(input int unsigned n_frames, input bit rough);
    int unsigned cols;
    int unsigned total;
    int unsigned slot;
    int unsigned density;
    int unsigned stop_at;
    cols = sb.used_cols();
    total = cols * sb.used_rows();
    stop_at = total;
    for (int unsigned f = 0; f < n_frames; f++) begin
      density = $urandom_range(0, 100);
      if (rough && f == n_frames - 1 && $urandom_range(0, 5) == 0) begin
        stop_at = $urandom_range(1, total - 1);
      end
      slot = 0;
      while (slot < stop_at) begin
        if (sb.tail_open() && slot < cols && $urandom_range(0, 3) == 0) begin
          send($urandom_range(0, 1), 1'b1);
          slot++;
        end else if (rough && !sb.tail_open() && $urandom_range(0, 39) == 0) begin
          send($urandom_range(0, 1), 1'b1);
        end else begin
          send($urandom_range(0, 99) < density, 1'b0);
          slot++;
        end
      end
    end
    if (stop_at == total && !(rough && $urandom_range(0, 7) == 0)) flush_tail();
    wait_drained();
  endtask

  function automatic logic [lcas_pkg::CFG_W-1:0] pick_size(input int unsigned mid_max);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return lcas_pkg::CFG_W'($urandom_range(2, 8));
    if (r < 9) return lcas_pkg::CFG_W'($urandom_range(9, mid_max));
    return lcas_pkg::CFG_W'($urandom_range(0, 1));
  endfunction

  initial begin
    int unsigned start_count;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_SPARE, 11'h2AA);
    config_grid(11'd3, 11'd3, 1'b0);
    send(1'b0, 1'b1);
    send(1'b1, 1'b1);
    send(1'b1, 1'b0);
    send(1'b1, 1'b0);
    send(1'b1, 1'b0);
    send(1'b0, 1'b0);
    send(1'b1, 1'b0);
    send(1'b1, 1'b1);
    send(1'b0, 1'b0);
    send(1'b1, 1'b0);
    send(1'b1, 1'b0);
    send(1'b1, 1'b0);
    send(1'b0, 1'b1);
    send(1'b1, 1'b1);
    send(1'b1, 1'b0);
    send(1'b0, 1'b0);
    send(1'b1, 1'b0);
    send(1'b1, 1'b0);
    send(1'b1, 1'b0);
    send(1'b1, 1'b0);
    send(1'b0, 1'b0);
    flush_tail();
    wait_drained();

    config_grid(11'd0, 11'd1, 1'b1);
    stream_frames(2, 1'b0);
    config_grid(11'd2047, 11'd0, 1'b0);
    stream_part(1324);
    config_grid(11'd1, 11'd2047, 1'b1);
    stream_part(40);

    start_count = useful_sent;
    while (useful_sent - start_count < RANDOM_ITEMS) begin
      config_grid(pick_size(40), pick_size(16), $urandom_range(0, 1));
      stream_frames($urandom_range(1, 4), 1'b1);
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("life_cell_automaton_step verification clean");
    end else begin
      $display("life_cell_automaton_step verification failed");
    end
    $finish;
  end

  initial begin
    lcas_pkg::result_t got;
    int unsigned popped;
    int unsigned hold_mark;
    int unsigned holds_left;
    int unsigned tick;
    int unsigned mode;
    popped = 0;
    hold_mark = 150;
    holds_left = 3;
    tick = 0;
    mode = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      tick++;
      if (pop && !empty) begin
        got.next_alive = next_alive;
        got.row = cell_row;
        got.col = cell_col;
        got.frame_end = frame_end;
        sb.check_result(got);
        popped++;
      end
      if (holds_left > 0 && popped >= hold_mark) begin
        holds_left--;
        hold_mark += 2000;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (tick % 64 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: begin
            pop <= 1'b1;
          end
          1: begin
            pop <= $urandom_range(0, 1);
          end
          2: begin
            pop <= (tick % 4 == 0);
          end
          default: begin
            pop <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("life_cell_automaton_step verification failed");
    $finish;
  end
endmodule
